// ===== rtl/core/c3s_pkg.sv =====
// shared constants, register codes and stage tag type for the 3x3 convolution stream
package c3s_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int TAPS          = 9;
   localparam int PIX_W         = 8;
   localparam int RAM_W         = 2 * PIX_W;
   localparam int ROW_W         = 12;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WEIGHTS_TOP  = 3'd0,
      CSR_WEIGHTS_MID  = 3'd1,
      CSR_WEIGHTS_BOT  = 3'd2,
      CSR_SCALE_Q12    = 3'd3,
      CSR_FRAME_WIDTH  = 3'd4,
      CSR_FRAME_HEIGHT = 3'd5
   } csr_index_type;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // per-request flags that travel down the pipeline
   typedef struct packed {
      logic pixel;
      logic emit;
      logic filt;
      logic last;
   } tag_type;

endpackage

// ===== rtl/core/c3s_ram.sv =====
// generic single-write, single-read ram with registered read data
module c3s_ram #(
   parameter int WIDTH = c3s_pkg::RAM_W,
   parameter int DEPTH = c3s_pkg::MAX_WIDTH_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/conv3x3_scaled_stream_top.sv =====
// 3x3 convolution of a raster grayscale stream with scale, rounding and clamp to 0..255
//
//  channel | direction | handshake               | payload
//  req     | in        | req_tvalid / req_tready | tdata: pixel_in[7:0]; tuser: kind
//  rsp     | out       | rsp_tvalid / rsp_tready | tdata: pixel_out[7:0]; tlast: frame_last
//  csr     | in        | csr_valid / csr_ready   | csr_index[2:0], csr_data[23:0]
//
// one request per clock while rsp is not stalled and no csr write is settling; a result
// leaves through the line ram read, the window, four adder/multiplier stages and the clamp.
// the line ram holds both previous rows of a column in one word, read and rewritten
// once per pixel. reset clears position and pipeline valids and loads default config; no ram clearing pass.
// req_tready drops for one cycle after each csr write while the frame size settles.
// a stalled rsp backs up the pipeline stage by stage; empty stages still take requests.
module conv3x3_scaled_stream_top #(
   parameter int MAX_WIDTH = c3s_pkg::MAX_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [c3s_pkg::PIX_W-1:0]        req_tdata,   // [7:0] pixel_in
   input  logic                             req_tuser,   // [0] kind
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [c3s_pkg::PIX_W-1:0]        rsp_tdata,   // [7:0] pixel_out
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [c3s_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [c3s_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WV_W  = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = c3s_pkg::ROW_W;
   localparam int TOT_W = WV_W + ROW_W;
   localparam int PIX_W = c3s_pkg::PIX_W;
   localparam int TAPS  = c3s_pkg::TAPS;

   // configuration
   logic [23:0]        weights_top_ff, weights_mid_ff, weights_bot_ff;
   logic signed [15:0] scale_ff;
   logic [10:0]        frame_width_ff;
   logic [11:0]        frame_height_ff;
   logic               settle_ff;
   logic               pos_clr;

   // frame size
   logic [WV_W-1:0]    w_eff;
   logic [COL_W-1:0]   w_m1;
   logic [ROW_W-1:0]   h_eff;
   logic [TOT_W-1:0]   total_in, total_ff, total_m1_ff;

   // position
   logic [ROW_W-1:0]   row_ff, row_in, row0;
   logic [COL_W-1:0]   col_ff, col_in, col0;
   logic [TOT_W-1:0]   ocount_ff, ocount_in, ocount0;

   logic               acc, is_flush, frame_done, enter;
   c3s_pkg::tag_type   tag_in;

   // pipeline
   logic [6:1]         vld_ff;
   logic [7:1]         rdy;
   logic               rsp_tvalid_ff;
   logic [PIX_W-1:0]   rsp_tdata_ff;
   logic               rsp_tlast_ff;

   c3s_pkg::tag_type   s1_tag_ff, s2_tag_ff, s3_tag_ff, s4_tag_ff, s5_tag_ff, s6_tag_ff;
   logic [PIX_W-1:0]   s1_px_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [PIX_W-1:0]   win_ff [TAPS];
   logic signed [7:0]  wt [TAPS];
   logic signed [16:0] prod_in [TAPS];
   logic signed [16:0] prod_ff [TAPS];
   logic signed [18:0] rsum_in [3];
   logic signed [18:0] rsum_ff [3];
   logic signed [19:0] sum_in, sum_ff;
   logic signed [35:0] scl_in, scl_ff;

   logic [c3s_pkg::RAM_W-1:0] ram_rd_data;
   logic [c3s_pkg::RAM_W-1:0] ram_wr_data;
   logic                      ram_wr_en, ram_rd_en;

   // rounding
   logic [23:0]        q;
   logic [11:0]        rem;
   logic               inc, pos;
   logic [24:0]        qr;
   logic [PIX_W-1:0]   out_val;

   // ---------------- frame size ----------------
   always_comb begin
      if (frame_width_ff < 11'd3) begin
         w_eff = WV_W'(3);
      end else if (int'(frame_width_ff) > MAX_WIDTH) begin
         w_eff = WV_W'(MAX_WIDTH);
      end else begin
         w_eff = WV_W'(frame_width_ff);
      end
      w_m1     = COL_W'(w_eff - WV_W'(1));
      h_eff    = (frame_height_ff < 12'd3) ? 12'd3 : frame_height_ff;
      total_in = TOT_W'(w_eff) * TOT_W'(h_eff);
   end

   // ---------------- handshake and position ----------------
   always_comb begin
      rdy[7] = !rsp_tvalid_ff || rsp_tready;
      for (int k = 6; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign req_tready = rdy[1] && !settle_ff;
   assign acc        = req_tvalid && req_tready;
   assign is_flush   = (req_tuser == c3s_pkg::KIND_FLUSH);
   assign frame_done = (row_ff >= h_eff);
   assign pos_clr    = csr_valid && csr_ready &&
                       ((csr_index == c3s_pkg::CSR_FRAME_WIDTH) ||
                        (csr_index == c3s_pkg::CSR_FRAME_HEIGHT));

   always_comb begin
      row0      = frame_done ? '0 : row_ff;
      col0      = frame_done ? '0 : col_ff;
      ocount0   = frame_done ? '0 : ocount_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      ocount_in = ocount_ff;
      tag_in    = '0;
      if (is_flush) begin
         tag_in.emit = frame_done && (ocount_ff < total_ff);
         tag_in.last = (ocount_ff == total_m1_ff);
         if (tag_in.emit) begin
            ocount_in = ocount_ff + TOT_W'(1);
            // frame fully drained: start over
            if (ocount_in == total_ff) begin
               ocount_in = '0;
               row_in    = '0;
               col_in    = '0;
            end
         end
      end else begin
         tag_in.pixel = 1'b1;
         tag_in.emit  = (row0 >= 12'd2) || ((row0 == 12'd1) && (col0 != '0));
         tag_in.filt  = (row0 >= 12'd2) && (col0 >= COL_W'(2));
         tag_in.last  = (ocount0 == total_m1_ff);
         if (col0 == w_m1) begin
            col_in = '0;
            row_in = row0 + 12'd1;
         end else begin
            col_in = col0 + COL_W'(1);
            row_in = row0;
         end
         ocount_in = tag_in.emit ? ocount0 + TOT_W'(1) : ocount0;
      end
      enter = acc && (tag_in.pixel || tag_in.emit);
   end

   // ---------------- line ram: {two rows above, row above} per column ----------------
   assign ram_rd_en   = acc && !is_flush;
   assign ram_wr_en   = vld_ff[1] && rdy[2] && s1_tag_ff.pixel;
   assign ram_wr_data = {ram_rd_data[PIX_W-1:0], s1_px_ff};

   c3s_ram #(
      .WIDTH (c3s_pkg::RAM_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (col0),
      .rd_data (ram_rd_data)
   );

   // ---------------- arithmetic ----------------
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         wt[k]     = weights_top_ff[8*k +: 8];
         wt[3 + k] = weights_mid_ff[8*k +: 8];
         wt[6 + k] = weights_bot_ff[8*k +: 8];
      end
      for (int k = 0; k < TAPS; k++) begin
         prod_in[k] = 17'(wt[k]) * 17'($signed({1'b0, win_ff[k]}));
      end
      for (int r = 0; r < 3; r++) begin
         rsum_in[r] = 19'(prod_ff[3*r]) + 19'(prod_ff[3*r + 1]) + 19'(prod_ff[3*r + 2]);
      end
      sum_in = 20'(rsum_ff[0]) + 20'(rsum_ff[1]) + 20'(rsum_ff[2]);
      scl_in = 36'(sum_ff) * 36'(scale_ff);
   end

   // round half to even, clamp to 0..255; non-filtered (border) results give 0
   always_comb begin
      q   = scl_ff[35:12];
      rem = scl_ff[11:0];
      inc = (rem > 12'd2048) || ((rem == 12'd2048) && q[0]);
      qr  = {1'b0, q} + 25'(inc);
      pos = !scl_ff[35] && (scl_ff != '0);
      if (!s6_tag_ff.filt || !pos) begin
         out_val = '0;
      end else if (qr > 25'd255) begin
         out_val = '1;
      end else begin
         out_val = qr[PIX_W-1:0];
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         weights_top_ff  <= 24'd0;
         weights_mid_ff  <= 24'd256;
         weights_bot_ff  <= 24'd0;
         scale_ff        <= 16'sd4096;
         frame_width_ff  <= 11'd640;
         frame_height_ff <= 12'd480;
         settle_ff       <= 1'b1;
         row_ff          <= '0;
         col_ff          <= '0;
         ocount_ff       <= '0;
         vld_ff          <= '0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         settle_ff <= csr_valid && csr_ready;
         // a frame size write restarts the frame position
         if (pos_clr) begin
            row_ff    <= '0;
            col_ff    <= '0;
            ocount_ff <= '0;
         end else if (acc) begin
            row_ff    <= row_in;
            col_ff    <= col_in;
            ocount_ff <= ocount_in;
         end
         if (rdy[1]) begin
            vld_ff[1] <= enter;
         end
         if (rdy[2]) begin
            vld_ff[2] <= vld_ff[1] && s1_tag_ff.emit;
         end
         for (int k = 3; k <= 6; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
         if (rdy[7]) begin
            rsp_tvalid_ff <= vld_ff[6];
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               c3s_pkg::CSR_WEIGHTS_TOP:  weights_top_ff  <= csr_data;
               c3s_pkg::CSR_WEIGHTS_MID:  weights_mid_ff  <= csr_data;
               c3s_pkg::CSR_WEIGHTS_BOT:  weights_bot_ff  <= csr_data;
               c3s_pkg::CSR_SCALE_Q12:    scale_ff        <= csr_data[15:0];
               c3s_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[10:0];
               c3s_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[11:0];
               default: ;
            endcase
         end
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      total_ff    <= total_in;
      total_m1_ff <= total_in - TOT_W'(1);
      if (rdy[1]) begin
         s1_tag_ff <= tag_in;
         s1_px_ff  <= req_tdata;
         s1_col_ff <= col0;
      end
      // window shifts one column per pixel leaving the ram stage
      if (vld_ff[1] && rdy[2] && s1_tag_ff.pixel) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= ram_rd_data[2*PIX_W-1:PIX_W];
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= ram_rd_data[PIX_W-1:0];
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[8] <= s1_px_ff;
      end
      if (rdy[2]) begin
         s2_tag_ff <= s1_tag_ff;
      end
      if (rdy[3]) begin
         s3_tag_ff <= s2_tag_ff;
         prod_ff   <= prod_in;
      end
      if (rdy[4]) begin
         s4_tag_ff <= s3_tag_ff;
         rsum_ff   <= rsum_in;
      end
      if (rdy[5]) begin
         s5_tag_ff <= s4_tag_ff;
         sum_ff    <= sum_in;
      end
      if (rdy[6]) begin
         s6_tag_ff <= s5_tag_ff;
         scl_ff    <= scl_in;
      end
      if (rdy[7]) begin
         rsp_tdata_ff <= out_val;
         rsp_tlast_ff <= s6_tag_ff.last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign csr_ready  = 1'b1;

   // ---------------- assertions ----------------
   // ram data must hold while the ram stage is stalled
   a_ram_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[1] && !rdy[2]) |=> $stable(ram_rd_data))
      else $error("line ram data changed under a stalled request");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      !settle_ff |-> (ocount_ff <= total_ff))
      else $error("output count ran past the frame size");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_ff <= h_eff)
      else $error("row counter ran past the frame height");

   a_filt_pixel: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[1] && s1_tag_ff.filt) |-> (s1_tag_ff.pixel && s1_tag_ff.emit))
      else $error("filtered result from a flush or silent request");

endmodule
